// File: hdl/differential_drive_odometry_macros.svh
// ----------------------------------------------------------------------------
// differential_drive_odometry assertion macros
// Concurrent assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

// same-cycle implication, disabled during reset
`define DDO_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ddo assertion failed");

// next-cycle implication, disabled during reset
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ddo assertion failed");

`endif

// File: hdl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and helpers for the wheel odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int IDX_W        = 5;
	localparam int MUL_W        = 34;
	localparam int PROD_W       = 2 * MUL_W;
	localparam int NUM_W        = 54;
	localparam int DEN_W        = 44;
	localparam int REM_W        = DEN_W;
	localparam int CNT_W        = $clog2(NUM_W);
	localparam int CFG_IDX_W    = 8;

	localparam logic [31:0] MPT_RESET = 32'd160878;
	localparam logic [31:0] IAL_RESET = 32'd778073859;

	localparam logic [CFG_IDX_W-1:0] REG_MPT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IAL = 8'd1;

	localparam logic signed [33:0] PI_Q        = 34'sd843314857;
	localparam logic signed [33:0] TWO_PI_Q    = 34'sd1686629714;
	localparam logic signed [33:0] HALF_PI_Q   = 34'sd421657428;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] MICRO       = 34'sd1000000;

	localparam logic signed [33:0] ATAN_Q28 [32] = '{
		34'sd210828714, 34'sd124459457, 34'sd65760959, 34'sd33381290,
		34'sd16755422, 34'sd8385879, 34'sd4193963, 34'sd2097109,
		34'sd1048571, 34'sd524287, 34'sd262144, 34'sd131072,
		34'sd65536, 34'sd32768, 34'sd16384, 34'sd8192,
		34'sd4096, 34'sd2048, 34'sd1024, 34'sd512,
		34'sd256, 34'sd128, 34'sd64, 34'sd32,
		34'sd16, 34'sd8, 34'sd4, 34'sd2,
		34'sd1, 34'sd0, 34'sd0, 34'sd0
	};

	// one classified sample between front and back
	typedef struct packed {
		logic signed [31:0] dlt_l;
		logic signed [31:0] dlt_r;
		logic [31:0]        dt;
		logic               zero;
	} item_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -68'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// apply sign and saturation to an unsigned quotient
	function automatic logic [31:0] sat_quot(input logic [NUM_W-1:0] q, input logic neg);
		logic [31:0] r;
		if (!neg)
			r = (q > NUM_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
		else
			r = (q > NUM_W'(32'h80000000)) ? 32'h80000000 : (~q[31:0] + 32'd1);
		return r;
	endfunction

	// magnitude of a signed product, cut to numerator width
	function automatic logic [NUM_W-1:0] mag(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-1:0] a;
		a = v[PROD_W-1] ? (~v + PROD_W'(1)) : v;
		return a[NUM_W-1:0];
	endfunction

endpackage

// File: hdl/ddo_front.sv
// ----------------------------------------------------------------------------
// ddo_front
// Accepts samples, forms count and time deltas, flags a zero interval.
// ----------------------------------------------------------------------------
module ddo_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [95:0]   s_tdata,   // left_count, right_count, sample_time
	input  logic          q_full,
	output logic          q_push,
	output ddo_pkg::item_t q_item
);
	import ddo_pkg::*;

	logic [31:0] last_left_q;
	logic [31:0] last_right_q;
	logic [31:0] last_time_q;
	logic [31:0] dt;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// deltas modulo 2^32 against the previous sample
	assign dt           = s_tdata[95:64] - last_time_q;
	assign q_item.dlt_l = s_tdata[31:0] - last_left_q;
	assign q_item.dlt_r = s_tdata[63:32] - last_right_q;
	assign q_item.dt    = dt;
	assign q_item.zero  = (dt == 32'd0);

	// previous sample registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_left_q  <= '0;
			last_right_q <= '0;
			last_time_q  <= '0;
		end else if (q_push) begin
			last_left_q  <= s_tdata[31:0];
			last_right_q <= s_tdata[63:32];
			last_time_q  <= s_tdata[95:64];
		end
	end

endmodule

// File: hdl/ddo_queue.sv
// ----------------------------------------------------------------------------
// ddo_queue
// Two-entry queue of classified samples between front and back.
// ----------------------------------------------------------------------------
module ddo_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ddo_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output ddo_pkg::item_t pop_item,
	output logic           empty
);
	import ddo_pkg::*;

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_item = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// File: hdl/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddo_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ddo_pkg::NUM_W-1:0] num,
	input  logic [ddo_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [ddo_pkg::NUM_W-1:0] quot
);
	import ddo_pkg::*;

	logic [REM_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [REM_W:0]   trial;
	logic             fit;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fit   = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quot  = quo_q;

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fit ? REM_W'(trial - {1'b0, den_q}) : trial[REM_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fit};
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(NUM_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/ddo_back.sv
// ----------------------------------------------------------------------------
// ddo_back
// Sequencer: wheel travel, CORDIC pose update, heading wrap, velocities.
// ----------------------------------------------------------------------------
module ddo_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  ddo_pkg::item_t                q_item,
	output logic                          q_pop,
	input  logic                          cfg_valid,
	input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [191:0]                  m_tdata,
	output logic [0:0]                    m_tuser
);
	import ddo_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_ML   = 5'd1;
	localparam logic [4:0] S_MR   = 5'd2;
	localparam logic [4:0] S_DR   = 5'd3;
	localparam logic [4:0] S_DIF  = 5'd4;
	localparam logic [4:0] S_MT   = 5'd5;
	localparam logic [4:0] S_TRN  = 5'd6;
	localparam logic [4:0] S_COR  = 5'd7;
	localparam logic [4:0] S_NEG  = 5'd8;
	localparam logic [4:0] S_MX   = 5'd9;
	localparam logic [4:0] S_MY   = 5'd10;
	localparam logic [4:0] S_DY   = 5'd11;
	localparam logic [4:0] S_WRP  = 5'd12;
	localparam logic [4:0] S_NX   = 5'd13;
	localparam logic [4:0] S_NY   = 5'd14;
	localparam logic [4:0] S_NW   = 5'd15;
	localparam logic [4:0] S_DIVS = 5'd16;
	localparam logic [4:0] S_DIVW = 5'd17;
	localparam logic [4:0] S_OUT  = 5'd18;

	logic [4:0]  state_q;
	logic [31:0] mpt_q;
	logic [31:0] ial_q;

	// pose state
	logic [31:0]        pose_x_q;
	logic [31:0]        pose_y_q;
	logic signed [31:0] pose_h_q;

	// working registers
	item_t                    item_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [31:0]       dl_q;
	logic signed [31:0]       dr_q;
	logic signed [31:0]       centre_q;
	logic signed [31:0]       diff_q;
	logic signed [31:0]       turn_q;
	logic signed [33:0]       x_q;
	logic signed [33:0]       y_q;
	logic signed [33:0]       z_q;
	logic                     neg_q;
	logic [IDX_W-1:0]         i_q;
	logic signed [33:0]       dx_q;
	logic signed [33:0]       dy_q;
	logic signed [33:0]       h_q;
	logic signed [PROD_W-1:0] numx_q;
	logic signed [PROD_W-1:0] numy_q;
	logic signed [PROD_W-1:0] numw_q;
	logic [31:0]              vx_q;
	logic [31:0]              vy_q;
	logic [31:0]              vw_q;

	// output register
	logic         out_valid_q;
	logic [191:0] out_data_q;
	logic         out_user_q;

	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic signed [32:0]      sum_lr;
	logic signed [32:0]      dif_lr;
	logic signed [33:0]      xs;
	logic signed [33:0]      ys;
	logic signed [33:0]      fold_z;
	logic                    fold_n;
	logic                    div_start;
	logic [NUM_W-1:0]        qx;
	logic [NUM_W-1:0]        qy;
	logic [NUM_W-1:0]        qw;
	logic                    dnx;
	logic                    dny;
	logic                    dnw;
	logic                    out_free;

	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_ML: begin
				mul_a = MUL_W'(item_q.dlt_l);
				mul_b = $signed({2'b00, mpt_q});
			end
			S_MR: begin
				mul_a = MUL_W'(item_q.dlt_r);
				mul_b = $signed({2'b00, mpt_q});
			end
			S_MT: begin
				mul_a = MUL_W'(diff_q);
				mul_b = $signed({2'b00, ial_q});
			end
			S_MX: begin
				mul_a = MUL_W'(centre_q);
				mul_b = x_q;
			end
			S_MY: begin
				mul_a = MUL_W'(centre_q);
				mul_b = y_q;
			end
			S_NX: begin
				mul_a = dx_q;
				mul_b = MICRO;
			end
			S_NY: begin
				mul_a = dy_q;
				mul_b = MICRO;
			end
			S_NW: begin
				mul_a = MUL_W'(turn_q);
				mul_b = MICRO;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// wheel sums and CORDIC shifts
	assign sum_lr = 33'(dl_q) + 33'(dr_q);
	assign dif_lr = 33'(dr_q) - 33'(dl_q);
	assign xs     = x_q >>> i_q;
	assign ys     = y_q >>> i_q;

	// fold heading into the CORDIC range
	always_comb begin
		fold_z = 34'(pose_h_q);
		fold_n = 1'b0;
		if (fold_z > HALF_PI_Q) begin
			fold_z = fold_z - PI_Q;
			fold_n = 1'b1;
		end else if (fold_z < -HALF_PI_Q) begin
			fold_z = fold_z + PI_Q;
			fold_n = 1'b1;
		end
	end

	assign div_start = (state_q == S_DIVS) && !item_q.zero;

	// rate dividers
	ddo_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(mag(numx_q)),
		.den(DEN_W'(item_q.dt)), .done(dnx), .quot(qx)
	);
	ddo_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(mag(numy_q)),
		.den(DEN_W'(item_q.dt)), .done(dny), .quot(qy)
	);
	ddo_div u_div_w (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(mag(prod_q)),
		.den({item_q.dt, 12'd0}), .done(dnw), .quot(qw)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty)
					item_q <= q_item;
			end
			S_MR:  dl_q <= sat32(prod_q >>> 16);
			S_DR:  dr_q <= sat32(prod_q >>> 16);
			S_DIF: begin
				centre_q <= sum_lr[32:1];
				diff_q   <= sat32(PROD_W'(dif_lr));
			end
			S_TRN: begin
				turn_q <= sat32(prod_q >>> 16);
				x_q    <= CORDIC_GAIN;
				y_q    <= '0;
				z_q    <= fold_z;
				neg_q  <= fold_n;
				i_q    <= '0;
			end
			S_COR: begin
				i_q <= i_q + IDX_W'(1);
				if (z_q >= 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - ATAN_Q28[i_q];
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + ATAN_Q28[i_q];
				end
			end
			S_NEG: begin
				if (neg_q) begin
					x_q <= -x_q;
					y_q <= -y_q;
				end
			end
			S_MY: dx_q <= prod_q[63:30];
			S_DY: begin
				dy_q <= prod_q[63:30];
				h_q  <= 34'(pose_h_q) + 34'(turn_q);
			end
			S_WRP: begin
				if (h_q < 0)
					h_q <= h_q + TWO_PI_Q;
				else if (h_q >= TWO_PI_Q)
					h_q <= h_q - TWO_PI_Q;
				else if (h_q > PI_Q)
					h_q <= h_q - TWO_PI_Q;
			end
			S_NY:   numx_q <= prod_q;
			S_NW:   numy_q <= prod_q;
			S_DIVS: begin
				numw_q <= prod_q;
				vx_q   <= '0;
				vy_q   <= '0;
				vw_q   <= '0;
			end
			S_DIVW: begin
				if (dnx && dny && dnw) begin
					vx_q <= sat_quot(qx, numx_q[PROD_W-1]);
					vy_q <= sat_quot(qy, numy_q[PROD_W-1]);
					vw_q <= sat_quot(qw, numw_q[PROD_W-1]);
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer, pose, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mpt_q       <= MPT_RESET;
			ial_q       <= IAL_RESET;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			pose_h_q    <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_user_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_MPT)
					mpt_q <= cfg_data;
				else if (cfg_index == REG_IAL)
					ial_q <= cfg_data;
			end
			if (out_valid_q && m_tready && (state_q != S_OUT))
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (!q_empty) state_q <= S_ML;
				S_ML:   state_q <= S_MR;
				S_MR:   state_q <= S_DR;
				S_DR:   state_q <= S_DIF;
				S_DIF:  state_q <= S_MT;
				S_MT:   state_q <= S_TRN;
				S_TRN:  state_q <= S_COR;
				S_COR:  if (i_q == IDX_W'(CORDIC_STEPS - 1)) state_q <= S_NEG;
				S_NEG:  state_q <= S_MX;
				S_MX:   state_q <= S_MY;
				S_MY:   state_q <= S_DY;
				S_DY:   state_q <= S_WRP;
				S_WRP: begin
					if (h_q >= 0 && h_q < TWO_PI_Q)
						state_q <= S_NX;
				end
				S_NX: begin
					pose_x_q <= pose_x_q + dx_q[31:0];
					pose_y_q <= pose_y_q + dy_q[31:0];
					pose_h_q <= h_q[31:0];
					state_q  <= S_NY;
				end
				S_NY:   state_q <= S_NW;
				S_NW:   state_q <= S_DIVS;
				S_DIVS: state_q <= item_q.zero ? S_OUT : S_DIVW;
				S_DIVW: if (dnx && dny && dnw) state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {1'b0, vw_q, vy_q, vx_q, pose_h_q[30:0],
							pose_y_q, pose_x_q};
						out_user_q  <= item_q.zero;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/differential_drive_odometry.sv
// Sequencing: each accepted sample runs through the back sequencer states to a result,
// repeating the wrap state when the summed heading is negative or reaches two pi, and
// waiting out output stalls; the rate dividers are skipped when the elapsed time is zero.
// Flow: the back takes the next sample only after the last result is registered, paced by the
// 24-step CORDIC loop and the 54-step bit-serial rate dividers; a two-entry queue buffers input.
// Reset: arst_n clears pose, previous counts and time; registers return to defaults.
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Differential-drive wheel odometry: pose and velocity from encoder samples.
// ----------------------------------------------------------------------------
module differential_drive_odometry (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [95:0]                   s_tdata,   // left_count, right_count, sample_time
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [191:0]                  m_tdata,   // pos_x, pos_y, heading, vel_x, vel_y, turn_rate
	output logic [0:0]                    m_tuser,   // zero_interval
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import ddo_pkg::*;

	item_t f_item;
	item_t b_item;
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;

	// register writes always taken
	assign cfg_ready = 1'b1;

	// front: delta forming
	ddo_front u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .q_full(full), .q_push(push), .q_item(f_item)
	);

	// queue between front and back
	ddo_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(f_item), .full(full),
		.pop(pop), .pop_item(b_item), .empty(empty)
	);

	// back: arithmetic sequencer
	ddo_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(empty), .q_item(b_item), .q_pop(pop),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

endmodule

// File: hdl/ddo_checker.sv
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level assertions for the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_macros.svh"

module ddo_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [95:0]                   s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [191:0]                  m_tdata,
	input logic [0:0]                    m_tuser,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0]                   cfg_data
);
	import ddo_pkg::*;

	// stalled result stays offered
	`DDO_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// zero interval forces all rates to zero
	`DDO_ASSERT_NOW(a_zero_rates, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[190:95] == '0)

	// heading stays within plus or minus pi
	`DDO_ASSERT_NOW(a_heading, clk, arst_n, m_tvalid,
		($signed(m_tdata[94:64]) <= 31'sd843314857) &&
		($signed(m_tdata[94:64]) >= -31'sd843314857))

	// padding bit of the result is clear
	`DDO_ASSERT_NOW(a_pad, clk, arst_n, m_tvalid, m_tdata[191] == 1'b0)

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);

// File: test/differential_drive_odometry_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_tb
// Drives encoder samples and register writes into the odometry block, runs a
// transaction-level pose and velocity predictor alongside it and checks every
// result transaction field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module differential_drive_odometry_tb;
	import ddo_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [95:0]          s_tdata;   // left_count, right_count, sample_time
	logic                 m_tvalid;
	logic                 m_tready;
	logic [191:0]         m_tdata;   // pos_x, pos_y, heading, vel_x, vel_y, turn_rate
	logic [0:0]           m_tuser;   // zero_interval
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	typedef struct {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [30:0] heading;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [31:0] turn_rate;
		logic        zero_interval;
	} pose_t;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd7;
	localparam int WATCHDOG_LIMIT = 5000;

	pose_t       pending_poses[$];
	int          fail_count = 0;
	int          idle_cycles = 0;
	bit          no_stall = 0;
	int          stall_left = 0;

	// predictor state and registers
	logic [31:0] mpt, ial;
	logic [31:0] prev_left, prev_right, last_stamp;
	logic [31:0] acc_x, acc_y;
	longint      acc_heading;

	differential_drive_odometry dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint per_second(input longint num, input longint den);
		return clamp32((num * 64'sd1000000) / den);
	endfunction

	// advance the pose by one sample and form the expected result
	task automatic advance_pose(input logic [31:0] l, input logic [31:0] r,
			input logic [31:0] t, output pose_t res);
		longint dl, dr, centre, turn, x, y, z, xs, ys, dx, dy, h, vx, vy, w;
		logic [31:0] dt;
		bit folded;
		dl = clamp32((longint'(int'(l - prev_left)) * longint'(mpt)) >>> 16);
		dr = clamp32((longint'(int'(r - prev_right)) * longint'(mpt)) >>> 16);
		centre = (dl + dr) >>> 1;
		turn = clamp32((clamp32(dr - dl) * longint'(ial)) >>> 16);
		dt = t - last_stamp;
		// rotation-mode cordic on the old heading, folded to the right half plane
		x = longint'(CORDIC_GAIN);
		y = 0;
		z = acc_heading;
		folded = 0;
		if (z > longint'(HALF_PI_Q)) begin
			z -= longint'(PI_Q);
			folded = 1;
		end else if (z < -longint'(HALF_PI_Q)) begin
			z += longint'(PI_Q);
			folded = 1;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(ATAN_Q28[i]);
			end else begin
				x += ys; y -= xs; z += longint'(ATAN_Q28[i]);
			end
		end
		if (folded) begin
			x = -x;
			y = -y;
		end
		dx = (centre * x) >>> 30;
		dy = (centre * y) >>> 30;
		acc_x += dx[31:0];
		acc_y += dy[31:0];
		// wrap heading into (-pi, pi]
		h = (acc_heading + turn) % longint'(TWO_PI_Q);
		if (h < 0)
			h += longint'(TWO_PI_Q);
		if (h > longint'(PI_Q))
			h -= longint'(TWO_PI_Q);
		acc_heading = h;
		vx = 0; vy = 0; w = 0;
		if (dt != 0) begin
			vx = per_second(dx, longint'(dt));
			vy = per_second(dy, longint'(dt));
			w = per_second(turn, longint'(dt) * 4096);
		end
		prev_left = l;
		prev_right = r;
		last_stamp = t;
		res.pos_x = acc_x;
		res.pos_y = acc_y;
		res.heading = h[30:0];
		res.vel_x = vx[31:0];
		res.vel_y = vy[31:0];
		res.turn_rate = w[31:0];
		res.zero_interval = (dt == 0);
	endtask

	// send one sample, then leave the input idle for the requested gap
	task automatic send_sample(input logic [31:0] l, input logic [31:0] r,
			input logic [31:0] t, input int gap);
		pose_t res;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {t, r, l};
		do @(posedge clk); while (!s_tready);
		advance_pose(l, r, t, res);
		pending_poses.push_back(res);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// hold off until every expected pose has come back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_poses.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		drain_results();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MPT)
			mpt = val;
		else if (idx == REG_IAL)
			ial = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (no_stall || p < 55)
			return 0;
		if (p < 95)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// edge cases: first sample, zero interval, huge jumps, field extremes
	task automatic test_directed_samples();
		send_sample(32'd10, 32'd20, 32'd1000, 0);
		send_sample(32'd15, 32'd40, 32'd1000, 1);
		send_sample(32'h7FFFFFFF, 32'h80000000, 32'd2000, 0);
		send_sample(32'h80000000, 32'h7FFFFFFF, 32'd2001, 0);
		send_sample(32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 2);
		send_sample(32'hFFFFFFFF, 32'h00000000, 32'h00000000, 0);
		for (int i = 0; i < 8; i++)
			send_sample(prev_left - 32'd3000, prev_right + 32'd3000,
				last_stamp + 32'd500, 0);
		for (int i = 0; i < 4; i++)
			send_sample(prev_left + 32'd2000, prev_right + 32'd2000,
				last_stamp + 32'd1, 0);
		send_sample(prev_left, prev_right, last_stamp, 0);
		send_sample(32'h55555555, 32'hAAAAAAAA, 32'h5A5A5A5A, 1);
	endtask

	// random traffic, mostly smooth motion with some wild samples
	task automatic test_random_motion(input int n);
		logic [31:0] l, r, t;
		int p;
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0)
				no_stall = ($urandom_range(0, 3) == 0);
			p = $urandom_range(0, 99);
			if (p < 5) begin
				l = $urandom; r = $urandom; t = $urandom;
			end else begin
				l = prev_left + 32'($signed($urandom_range(0, 8000)) - 4000);
				r = prev_right + 32'($signed($urandom_range(0, 8000)) - 4000);
				if (p < 10)
					t = last_stamp;
				else
					t = last_stamp + $urandom_range(1, 40000);
			end
			send_sample(l, r, t, pick_gap());
			if (i == n / 2)
				drain_results();
		end
		no_stall = 0;
	endtask

	// register settings including extremes, each set followed by traffic
	task automatic test_register_sweep();
		write_reg(REG_MPT, 32'hFFFFFFFF);
		write_reg(REG_IAL, 32'hFFFFFFFF);
		test_random_motion(150);
		write_reg(REG_MPT, 32'd0);
		write_reg(REG_IAL, 32'd0);
		test_random_motion(100);
		write_reg(REG_UNUSED, 32'h12345678);
		write_reg(REG_MPT, $urandom);
		write_reg(REG_IAL, $urandom);
		test_random_motion(150);
		write_reg(REG_MPT, 32'd2000000);
		write_reg(REG_IAL, 32'd1500000000);
		test_random_motion(150);
		write_reg(REG_MPT, MPT_RESET);
		write_reg(REG_IAL, IAL_RESET);
		test_random_motion(580);
	endtask

	// result checker
	always @(posedge clk) begin
		pose_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_poses.size() == 0) begin
				$error("unexpected result transaction");
				fail_count++;
			end else begin
				e = pending_poses.pop_front();
				if (m_tdata[31:0] !== e.pos_x) begin
					$error("pos_x expected %0d got %0d", $signed(e.pos_x),
						$signed(m_tdata[31:0]));
					fail_count++;
				end
				if (m_tdata[63:32] !== e.pos_y) begin
					$error("pos_y expected %0d got %0d", $signed(e.pos_y),
						$signed(m_tdata[63:32]));
					fail_count++;
				end
				if (m_tdata[94:64] !== e.heading) begin
					$error("heading expected %0d got %0d", $signed(e.heading),
						$signed(m_tdata[94:64]));
					fail_count++;
				end
				if (m_tdata[126:95] !== e.vel_x) begin
					$error("vel_x expected %0d got %0d", $signed(e.vel_x),
						$signed(m_tdata[126:95]));
					fail_count++;
				end
				if (m_tdata[158:127] !== e.vel_y) begin
					$error("vel_y expected %0d got %0d", $signed(e.vel_y),
						$signed(m_tdata[158:127]));
					fail_count++;
				end
				if (m_tdata[190:159] !== e.turn_rate) begin
					$error("turn_rate expected %0d got %0d", $signed(e.turn_rate),
						$signed(m_tdata[190:159]));
					fail_count++;
				end
				if (m_tuser[0] !== e.zero_interval) begin
					$error("zero_interval expected %0d got %0d", e.zero_interval,
						m_tuser[0]);
					fail_count++;
				end
			end
		end
	end

	// receiver stalls, mostly short with a few long ones
	always @(negedge clk) begin
		int p;
		if (stall_left > 0) begin
			stall_left--;
			m_tready = 1'b0;
		end else if (no_stall) begin
			m_tready = 1'b1;
		end else begin
			p = $urandom_range(0, 99);
			if (p < 2) begin
				stall_left = $urandom_range(20, 60);
				m_tready = 1'b0;
			end else if (p < 20) begin
				stall_left = $urandom_range(0, 3);
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("differential_drive_odometry_tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mpt = MPT_RESET;
		ial = IAL_RESET;
		prev_left = '0; prev_right = '0; last_stamp = '0;
		acc_x = '0; acc_y = '0; acc_heading = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_samples();
		test_register_sweep();

		drain_results();
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("differential_drive_odometry_tb: clean");
		else
			$display("differential_drive_odometry_tb: errors");
		$finish;
	end

endmodule
